FILE: rtl/core/tdcwp_pkg.sv
// Shared types and constants for the TDC readout word parser.
package tdcwp_pkg;

   // Word types carried in bits 30..27 of a defining word
   localparam logic [3:0] WT_BLOCK_HDR = 4'd0;
   localparam logic [3:0] WT_BLOCK_TRL = 4'd1;
   localparam logic [3:0] WT_EVENT_HDR = 4'd2;
   localparam logic [3:0] WT_TRIG_TIME = 4'd3;
   localparam logic [3:0] WT_HIT_DATA  = 4'd7;

   // Result kinds
   localparam logic [2:0] KIND_HIT          = 3'd0;
   localparam logic [2:0] KIND_EVENT_START  = 3'd1;
   localparam logic [2:0] KIND_EARLY_TRL    = 3'd2;
   localparam logic [2:0] KIND_EVT_NO_BLOCK = 3'd3;
   localparam logic [2:0] KIND_SLOT_MISM    = 3'd4;
   localparam logic [2:0] KIND_TIME_NO_HDR  = 3'd5;
   localparam logic [2:0] KIND_DATA_NO_HDR  = 3'd6;
   localparam logic [2:0] KIND_DATA_NO_EVT  = 3'd7;

   // Result queue geometry
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   typedef struct packed {
      logic [31:0] data_word;
      logic        bank_start;
      logic [15:0] roc_id;
      logic [47:0] first_event;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] crate;
      logic [4:0]  slot;
      logic [3:0]  board;
      logic [47:0] event_num;
      logic [47:0] trigger_time;
      logic [2:0]  group;
      logic [4:0]  channel;
      logic        edge_res;
      logic [9:0]  coarse;
      logic        half_step;
      logic [6:0]  fine;
   } rsp_type;

   // Front-end status seen by the top level
   typedef struct packed {
      logic push;
      logic halted;
   } front_stat_type;

   function automatic logic is_error_kind(input logic [2:0] k);
      return (k != KIND_HIT) && (k != KIND_EVENT_START);
   endfunction

endpackage

FILE: rtl/core/tdcwp_front.sv
// Front end: decodes readout words, tracks bank/block/event state, builds records.
module tdcwp_front
   import tdcwp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           acc,
   input  req_type        req,
   output rsp_type        rec,
   output front_stat_type stat
);

   logic        in_block_ff, in_block_in;
   logic [7:0]  events_left_ff, events_left_in;
   logic [4:0]  cur_slot_ff, cur_slot_in;
   logic [3:0]  cur_board_ff, cur_board_in;
   logic [47:0] time_reg_ff, time_reg_in;
   logic        await_high_ff, await_high_in;
   logic [23:0] time_low_hold_ff, time_low_hold_in;
   logic [47:0] event_reg_ff, event_reg_in;
   logic [47:0] event_count_ff, event_count_in;
   logic        seen_event_ff, seen_event_in;
   logic        halted_ff, halted_in;
   logic [15:0] crate_hold_ff, crate_hold_in;
   logic [47:0] base_event_ff, base_event_in;

   logic        push;
   logic [2:0]  kind;
   logic        hit;
   logic [31:0] w;

   assign w = req.data_word;

   // Next-state decode for one item
   always_comb begin
      in_block_in      = in_block_ff;
      events_left_in   = events_left_ff;
      cur_slot_in      = cur_slot_ff;
      cur_board_in     = cur_board_ff;
      time_reg_in      = time_reg_ff;
      await_high_in    = await_high_ff;
      time_low_hold_in = time_low_hold_ff;
      event_reg_in     = event_reg_ff;
      event_count_in   = event_count_ff;
      seen_event_in    = seen_event_ff;
      halted_in        = halted_ff;
      crate_hold_in    = crate_hold_ff;
      base_event_in    = base_event_ff;
      push             = 1'b0;
      kind             = KIND_HIT;
      hit              = 1'b0;

      // bank start clears the state and loads crate and first event, then the word is decoded as usual
      if (req.bank_start) begin
         in_block_in      = 1'b0;
         events_left_in   = '0;
         cur_slot_in      = '0;
         cur_board_in     = '0;
         time_reg_in      = '0;
         await_high_in    = 1'b0;
         time_low_hold_in = '0;
         event_reg_in     = '0;
         event_count_in   = '0;
         seen_event_in    = 1'b0;
         halted_in        = 1'b0;
         crate_hold_in    = req.roc_id;
         base_event_in    = req.first_event;
      end

      if (!halted_in) begin
         if (await_high_in) begin
            // second trigger time word, whatever its type
            await_high_in = 1'b0;
            time_reg_in   = {w[23:0], time_low_hold_in};
         end else if (w[31]) begin
            case (w[30:27])
               WT_BLOCK_HDR: begin
                  in_block_in    = 1'b1;
                  cur_slot_in    = w[26:22];
                  cur_board_in   = w[21:18];
                  events_left_in = w[7:0];
               end
               WT_BLOCK_TRL: begin
                  if (!in_block_in || events_left_in != 8'd0) begin
                     push      = 1'b1;
                     kind      = KIND_EARLY_TRL;
                     halted_in = 1'b1;
                  end else begin
                     in_block_in    = 1'b0;
                     event_count_in = '0;
                  end
               end
               WT_EVENT_HDR: begin
                  if (!in_block_in || events_left_in == 8'd0) begin
                     push      = 1'b1;
                     kind      = KIND_EVT_NO_BLOCK;
                     halted_in = 1'b1;
                  end else begin
                     events_left_in = events_left_in - 8'd1;
                     if (w[26:22] != cur_slot_in) begin
                        push      = 1'b1;
                        kind      = KIND_SLOT_MISM;
                        halted_in = 1'b1;
                     end else begin
                        event_reg_in   = base_event_in + event_count_in;
                        event_count_in = event_count_in + 48'd1;
                        seen_event_in  = 1'b1;
                        push           = 1'b1;
                        kind           = KIND_EVENT_START;
                     end
                  end
               end
               WT_TRIG_TIME: begin
                  if (!in_block_in) begin
                     push      = 1'b1;
                     kind      = KIND_TIME_NO_HDR;
                     halted_in = 1'b1;
                  end else begin
                     time_low_hold_in = w[23:0];
                     await_high_in    = 1'b1;
                  end
               end
               WT_HIT_DATA: begin
                  push = 1'b1;
                  if (!in_block_in) begin
                     kind      = KIND_DATA_NO_HDR;
                     halted_in = 1'b1;
                  end else if (!seen_event_in) begin
                     kind      = KIND_DATA_NO_EVT;
                     halted_in = 1'b1;
                  end else begin
                     kind = KIND_HIT;
                     hit  = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Record assembly from the post-update state
   always_comb begin
      rec.kind         = kind;
      rec.crate        = crate_hold_in;
      rec.slot         = cur_slot_in;
      rec.board        = cur_board_in;
      rec.event_num    = event_reg_in;
      rec.trigger_time = (kind == KIND_EVENT_START) ? 48'd0 : time_reg_in;
      rec.group        = hit ? w[26:24] : 3'd0;
      rec.channel      = hit ? w[23:19] : 5'd0;
      rec.edge_res     = hit ? w[18]    : 1'b0;
      rec.coarse       = hit ? w[17:8]  : 10'd0;
      rec.half_step    = hit ? w[7]     : 1'b0;
      rec.fine         = hit ? w[6:0]   : 7'd0;
   end

   assign stat.push   = acc && push;
   assign stat.halted = halted_ff;

   // State registers, updated per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff      <= 1'b0;
         events_left_ff   <= '0;
         cur_slot_ff      <= '0;
         cur_board_ff     <= '0;
         time_reg_ff      <= '0;
         await_high_ff    <= 1'b0;
         time_low_hold_ff <= '0;
         event_reg_ff     <= '0;
         event_count_ff   <= '0;
         seen_event_ff    <= 1'b0;
         halted_ff        <= 1'b0;
         crate_hold_ff    <= '0;
         base_event_ff    <= '0;
      end else if (acc) begin
         in_block_ff      <= in_block_in;
         events_left_ff   <= events_left_in;
         cur_slot_ff      <= cur_slot_in;
         cur_board_ff     <= cur_board_in;
         time_reg_ff      <= time_reg_in;
         await_high_ff    <= await_high_in;
         time_low_hold_ff <= time_low_hold_in;
         event_reg_ff     <= event_reg_in;
         event_count_ff   <= event_count_in;
         seen_event_ff    <= seen_event_in;
         halted_ff        <= halted_in;
         crate_hold_ff    <= crate_hold_in;
         base_event_ff    <= base_event_in;
      end
   end

endmodule

FILE: rtl/core/tdcwp_queue.sv
// Back end: record queue between the decoder and the result channel.
module tdcwp_queue
   import tdcwp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_type      push_rec,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data,
   output logic [QAW:0] level
);

   rsp_type        slot_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;
   logic           pop;

   assign full      = (count_ff == (QAW+1)'(QDEPTH));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign level     = count_ff;

   // Pointer and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QAW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QAW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

FILE: rtl/core/tdc_readout_word_parser.sv
// Top level of the TDC readout word parser.
// Takes one 32-bit readout word per clock and yields at most one record per word: a hit,
// an event start or an error; after an error every word is dropped until the next bank
// start. A word is decoded and the parser state updated in the cycle it is accepted, and
// its record is queued behind any older ones for the rsp_ channel. A four-entry record
// queue sits between decoder and output, so req_stall rises only when that queue is full;
// with the result side never stalling, the sustained rate is one word per cycle.
module tdc_readout_word_parser
   import tdcwp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic           req_acc;
   logic           q_full;
   logic [QAW:0]   q_level;
   rsp_type        rec;
   front_stat_type fstat;

   assign req_stall = q_full;
   assign req_acc   = req_valid && !q_full;

   // Decoder and state
   tdcwp_front u_front (
      .clock (clock),
      .reset (reset),
      .acc   (req_acc),
      .req   (req_data),
      .rec   (rec),
      .stat  (fstat)
   );

   // Record queue and output
   tdcwp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fstat.push),
      .push_rec  (rec),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .level     (q_level)
   );

`ifndef SYNTHESIS
   // queue never overfills
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= (QAW+1)'(QDEPTH))
      else $error("record queue over depth");

   // an error record leaves the parser halted
   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      fstat.push && is_error_kind(rec.kind) |=> fstat.halted)
      else $error("error record without halt");

   // while halted only a bank start can produce a record
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      fstat.halted && req_acc && !req_data.bank_start |-> !fstat.push)
      else $error("record produced while halted");
`endif

endmodule

FILE: verif/tdc_readout_word_parser_tb.sv
// Self-checking testbench for the TDC readout word parser: directed, random and back-pressure tests.
module tdc_readout_word_parser_tb
   import tdcwp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // A defining word type that the parser does not decode
   localparam logic [3:0] WT_SPARE = 4'd15;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Records still owed by the parser, oldest first
   rsp_type pending_records[$];
   int      mismatches = 0;
   int      words_sent = 0;
   int      noise_sent = 0;
   bit      gaps_on = 1'b1;
   bit      hold_off_req = 1'b0;
   int      hold_count = 0;

   // Mirror of the parser state
   bit          blk_open;
   logic [7:0]  evts_remaining;
   logic [4:0]  hdr_slot;
   logic [3:0]  hdr_board;
   logic [47:0] trig_time;
   bit          high_pending;
   logic [23:0] low_half;
   logic [47:0] cur_event;
   logic [47:0] evt_index;
   bit          event_seen;
   bit          parser_halted;
   logic [15:0] bank_crate;
   logic [47:0] bank_base;

   tdc_readout_word_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Decode one accepted word; returns 1 when the parser owes a record for it
   function automatic bit decode_word(input req_type w, output rsp_type rec);
      logic [31:0] d;
      d = w.data_word;
      rec = '0;
      if (w.bank_start) begin
         blk_open       = 1'b0;
         evts_remaining = '0;
         hdr_slot       = '0;
         hdr_board      = '0;
         trig_time      = '0;
         high_pending   = 1'b0;
         low_half       = '0;
         cur_event      = '0;
         evt_index      = '0;
         event_seen     = 1'b0;
         parser_halted  = 1'b0;
         bank_crate     = w.roc_id;
         bank_base      = w.first_event;
      end
      if (parser_halted)
         return 1'b0;
      // second time word: high half, whatever its type
      if (high_pending) begin
         high_pending = 1'b0;
         trig_time    = {d[23:0], low_half};
         return 1'b0;
      end
      if (!d[31])
         return 1'b0;
      rec.crate        = bank_crate;
      rec.slot         = hdr_slot;
      rec.board        = hdr_board;
      rec.event_num    = cur_event;
      rec.trigger_time = trig_time;
      case (d[30:27])
         WT_BLOCK_HDR: begin
            blk_open       = 1'b1;
            hdr_slot       = d[26:22];
            hdr_board      = d[21:18];
            evts_remaining = d[7:0];
            return 1'b0;
         end
         WT_BLOCK_TRL: begin
            if (!blk_open || evts_remaining != 0) begin
               rec.kind      = KIND_EARLY_TRL;
               parser_halted = 1'b1;
               return 1'b1;
            end
            blk_open  = 1'b0;
            evt_index = '0;
            return 1'b0;
         end
         WT_EVENT_HDR: begin
            if (!blk_open || evts_remaining == 0) begin
               rec.kind      = KIND_EVT_NO_BLOCK;
               parser_halted = 1'b1;
               return 1'b1;
            end
            evts_remaining = evts_remaining - 8'd1;
            if (d[26:22] != hdr_slot) begin
               rec.kind      = KIND_SLOT_MISM;
               parser_halted = 1'b1;
               return 1'b1;
            end
            cur_event        = bank_base + evt_index;
            evt_index        = evt_index + 48'd1;
            event_seen       = 1'b1;
            rec.kind         = KIND_EVENT_START;
            rec.event_num    = cur_event;
            rec.trigger_time = '0;
            return 1'b1;
         end
         WT_TRIG_TIME: begin
            if (!blk_open) begin
               rec.kind      = KIND_TIME_NO_HDR;
               parser_halted = 1'b1;
               return 1'b1;
            end
            low_half     = d[23:0];
            high_pending = 1'b1;
            return 1'b0;
         end
         WT_HIT_DATA: begin
            if (!blk_open || !event_seen) begin
               rec.kind      = blk_open ? KIND_DATA_NO_EVT : KIND_DATA_NO_HDR;
               parser_halted = 1'b1;
               return 1'b1;
            end
            rec.kind      = KIND_HIT;
            rec.group     = d[26:24];
            rec.channel   = d[23:19];
            rec.edge_res  = d[18];
            rec.coarse    = d[17:8];
            rec.half_step = d[7];
            rec.fine      = d[6:0];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [31:0] make_def(input logic [3:0] wt, input logic [26:0] payload);
      return {1'b1, wt, payload};
   endfunction

   // Item with random crate id and first event number
   function automatic req_type word_item(input logic [31:0] d, input logic bs);
      req_type r;
      r.data_word   = d;
      r.bank_start  = bs;
      r.roc_id      = 16'($urandom);
      r.first_event = {16'($urandom), 32'($urandom)};
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [47:0] want,
                                       input logic [47:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Offer one item, hold it until taken, then predict its record
   task automatic send_item(input req_type r);
      rsp_type rec;
      while (gaps_on && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (decode_word(r, rec))
         pending_records = {pending_records, rec};
      words_sent++;
   endtask

   task automatic send_word(input logic [31:0] d);
      send_item(word_item(d, 1'b0));
   endtask

   task automatic send_bank(input logic [31:0] d);
      send_item(word_item(d, 1'b1));
   endtask

   // Continuation words, undecoded types and the odd stray word
   task automatic send_noise();
      logic [31:0] d;
      d = $urandom;
      case ($urandom_range(3))
         0: d[31] = 1'b0;
         1: d[31:27] = {1'b1, 4'($urandom_range(4, 6))};
         2: d[31:27] = {1'b1, 4'($urandom_range(8, 15))};
         default: ;
      endcase
      noise_sent++;
      send_item(word_item(d, $urandom_range(49) == 0));
   endtask

   // Mostly well-formed banks with random content, plus broken sequences
   task automatic send_random_banks(input int quota);
      int          start_mark;
      int          n_blocks;
      int          n_evt;
      int          n_send;
      int          n_hits;
      logic [4:0]  slot;
      logic [3:0]  wt;
      req_type     r;
      start_mark = words_sent - noise_sent;
      while (words_sent - noise_sent - start_mark < quota) begin
         n_blocks = $urandom_range(1, 3);
         for (int b = 0; b < n_blocks; b++) begin
            slot  = 5'($urandom);
            n_evt = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
            r = word_item(make_def(WT_BLOCK_HDR,
                                   {slot, 4'($urandom), 10'($urandom), 8'(n_evt)}), b == 0);
            if ($urandom_range(4) == 0)
               r.first_event = '1 - 48'($urandom_range(3));
            send_item(r);
            // hit ahead of the first event
            if ($urandom_range(29) == 0)
               send_word(make_def(WT_HIT_DATA, 27'($urandom)));
            n_send = (n_evt > 4) ? $urandom_range(4) : n_evt;
            for (int e = 0; e < n_send; e++) begin
               if ($urandom_range(9) == 0)
                  send_noise();
               send_word(make_def(WT_EVENT_HDR,
                                  {($urandom_range(19) == 0) ? 5'($urandom) : slot,
                                   22'($urandom)}));
               if ($urandom_range(9) != 0) begin
                  send_word(make_def(WT_TRIG_TIME, 27'($urandom)));
                  send_word($urandom);
               end
               n_hits = $urandom_range(4);
               for (int h = 0; h < n_hits; h++) begin
                  if ($urandom_range(9) == 0)
                     send_noise();
                  send_word(make_def(WT_HIT_DATA, 27'($urandom)));
               end
               if ($urandom_range(19) == 0)
                  send_word(make_def(4'($urandom), 27'($urandom)));
            end
            // block header inside a block overrides the count
            if ($urandom_range(19) == 0)
               send_word(make_def(WT_BLOCK_HDR, {5'($urandom), 4'($urandom), 10'($urandom),
                                                 8'($urandom_range(1))}));
            send_word(make_def(WT_BLOCK_TRL, 27'($urandom)));
            // word out of order after the trailer
            if ($urandom_range(19) == 0) begin
               case ($urandom_range(3))
                  0: wt = WT_EVENT_HDR;
                  1: wt = WT_TRIG_TIME;
                  2: wt = WT_HIT_DATA;
                  default: wt = WT_BLOCK_TRL;
               endcase
               send_word(make_def(wt, 27'($urandom)));
            end
         end
      end
   endtask

   // Field extremes, wrap of the event number, ignored words, header override
   task automatic test_directed_bank();
      req_type r;
      r = word_item(make_def(WT_BLOCK_HDR, {5'd31, 4'd15, 10'h3FF, 8'd2}), 1'b1);
      r.roc_id      = 16'hFFFF;
      r.first_event = '1;
      send_item(r);
      send_word(make_def(WT_EVENT_HDR, {5'd31, 22'h3FFFFF}));
      send_word(make_def(WT_TRIG_TIME, '1));
      send_word(make_def(WT_HIT_DATA, '1));
      send_word(make_def(WT_HIT_DATA, '1));
      send_word(make_def(WT_HIT_DATA, '0));
      send_word(32'h7FFF_FFFF);
      send_word(make_def(WT_SPARE, '1));
      send_word(make_def(WT_BLOCK_HDR, {5'd0, 4'd0, 10'd0, 8'd1}));
      send_word(make_def(WT_EVENT_HDR, '0));
      send_word(make_def(WT_BLOCK_TRL, '0));
      // trailer outside a block, then a word while halted
      send_word(make_def(WT_BLOCK_TRL, '1));
      send_word(make_def(WT_HIT_DATA, '1));
   endtask

   // Every error kind, and a pending high half dropped by a bank start
   task automatic test_error_paths();
      req_type r;
      r = word_item(make_def(WT_EVENT_HDR, '0), 1'b1);
      r.roc_id      = '0;
      r.first_event = '0;
      send_item(r);
      send_bank(make_def(WT_TRIG_TIME, 27'($urandom)));
      send_bank(make_def(WT_HIT_DATA, 27'($urandom)));
      send_bank(make_def(WT_BLOCK_HDR, {5'd5, 4'd7, 10'd0, 8'd1}));
      send_word(make_def(WT_HIT_DATA, 27'($urandom)));
      send_bank(make_def(WT_BLOCK_HDR, {5'd5, 4'd7, 10'd0, 8'd1}));
      send_word(make_def(WT_EVENT_HDR, {5'd6, 22'd0}));
      send_bank(make_def(WT_BLOCK_HDR, {5'd2, 4'd1, 10'd0, 8'd0}));
      send_word(make_def(WT_EVENT_HDR, {5'd2, 22'd0}));
      send_bank(make_def(WT_BLOCK_HDR, {5'd2, 4'd1, 10'd0, 8'd2}));
      send_word(make_def(WT_BLOCK_TRL, '0));
      send_bank(make_def(WT_BLOCK_HDR, {5'd3, 4'd2, 10'd0, 8'd1}));
      send_word(make_def(WT_EVENT_HDR, {5'd3, 22'd0}));
      send_word(make_def(WT_TRIG_TIME, 27'($urandom)));
      send_bank(make_def(WT_BLOCK_HDR, {5'd3, 4'd2, 10'd0, 8'd1}));
      send_word(make_def(WT_HIT_DATA, 27'($urandom)));
   endtask

   task automatic test_random_banks();
      send_random_banks(300);
   endtask

   // No idling on either side
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      send_random_banks(120);
      gaps_on = 1'b1;
   endtask

   // Receiver holds off while hits keep coming, so the record queue fills
   task automatic test_backpressure();
      gaps_on      = 1'b0;
      hold_off_req = 1'b1;
      send_bank(make_def(WT_BLOCK_HDR, {5'd9, 4'd3, 10'd0, 8'd1}));
      send_word(make_def(WT_EVENT_HDR, {5'd9, 22'($urandom)}));
      send_word(make_def(WT_TRIG_TIME, 27'($urandom)));
      send_word($urandom);
      repeat (40)
         send_word(make_def(WT_HIT_DATA, 27'($urandom)));
      send_word(make_def(WT_BLOCK_TRL, 27'($urandom)));
      gaps_on = 1'b1;
   endtask

   // Result side: random stalls, or a counted hold-off on request
   always @(posedge clock) begin
      if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count--;
      end else if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_count   = 60;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(99) < 11);
      end
   end

   // Compare each taken record with the oldest one owed
   always @(posedge clock) begin : record_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_records.size() == 0) begin
            $error("unexpected record: kind %0d", rsp_data.kind);
            mismatches++;
         end else begin
            want = pending_records.pop_front();
            check_field("kind", 48'(want.kind), 48'(rsp_data.kind));
            check_field("crate", 48'(want.crate), 48'(rsp_data.crate));
            check_field("slot", 48'(want.slot), 48'(rsp_data.slot));
            check_field("board", 48'(want.board), 48'(rsp_data.board));
            check_field("event_num", want.event_num, rsp_data.event_num);
            check_field("trigger_time", want.trigger_time, rsp_data.trigger_time);
            check_field("group", 48'(want.group), 48'(rsp_data.group));
            check_field("channel", 48'(want.channel), 48'(rsp_data.channel));
            check_field("edge_res", 48'(want.edge_res), 48'(rsp_data.edge_res));
            check_field("coarse", 48'(want.coarse), 48'(rsp_data.coarse));
            check_field("half_step", 48'(want.half_step), 48'(rsp_data.half_step));
            check_field("fine", 48'(want.fine), 48'(rsp_data.fine));
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_bank();
      test_error_paths();
      test_random_banks();
      test_back_to_back();
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_records.size() != 0)
         @(posedge clock);
      // catch any stray record after the last one owed
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: tdc_readout_word_parser.f
rtl/core/tdcwp_pkg.sv
rtl/core/tdcwp_front.sv
rtl/core/tdcwp_queue.sv
rtl/core/tdc_readout_word_parser.sv
verif/tdc_readout_word_parser_tb.sv
